// ===== design/tkil_pkg.sv =====
// tkil_pkg: status codes and character constants shared by the trie core
// no dependencies
`default_nettype none

package tkil_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_BAD_CHAR  = 2'd2;
  localparam status_t ST_POOL_FULL = 2'd3;

  localparam logic [7:0] FIRST_LETTER = 8'd97;  // 'a'
  localparam logic [7:0] LAST_OFFSET  = 8'd25;  // 'z' - 'a'

endpackage

`default_nettype wire

// ===== design/tkil_ram.sv =====
// tkil_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module tkil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/trie_key_insert_lookup_core.sv =====
// trie_key_insert_lookup_core: lowercase-key trie with insert and find
// depends on tkil_pkg and tkil_ram (child row table, value table)
//
//  channel  ports                                            handshake
//  -------  -----------------------------------------------  ------------------------
//  input    in_op in_end_of_key in_char_code in_entry_value  start & !busy
//  result   out_status out_found_value                       out_valid, one cycle
//
// a character item passes through S_LINK (child row read, then decide), and also
// through S_ZERO when a new node is allocated (zeroing the new node's child row);
// the child row table has a registered read
// an end item is done in S_IDLE, a find that reads the value table goes on to S_VAL
// after reset the init state zeroes the root row and root value entry, busy high
// results are strobed for one cycle and cannot be stalled
`default_nettype none

module trie_key_insert_lookup_core import tkil_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic        in_end_of_key,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [31:0] in_entry_value,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value
);

  localparam int NW      = $clog2(NODE_COUNT);
  localparam int UW      = $clog2(NODE_COUNT + 1);
  localparam int LW      = $clog2(ALPHABET_SIZE);
  localparam int ROW_W   = ALPHABET_SIZE * NW;
  localparam int STORE_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic [UW-1:0] POOL_LIM  = UW'(NODE_COUNT);
  localparam logic [7:0]    ALPHA_LIM = 8'(ALPHABET_SIZE);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_VAL  = 3'd4;

  typedef logic [ALPHABET_SIZE-1:0][NW-1:0] row_t;

  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt;
  status_t       abort_r, abort_nxt;
  logic [UW-1:0] nodes_used_r, nodes_used_nxt;
  logic          op_r, op_nxt;
  logic [LW-1:0] letter_r, letter_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [31:0]   out_value_r, out_value_nxt;

  logic [ROW_W-1:0]   link_rdata, link_wdata;
  logic               link_we;
  logic [STORE_W:0]   val_rdata, val_wdata;
  logic               val_we;
  logic [NW-1:0]      val_waddr;

  row_t          row_rd, row_wr;
  logic [NW-1:0] link_sel, new_node;
  logic [7:0]    char_off;
  logic          char_ok, accept;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign char_off = in_char_code - FIRST_LETTER;
  assign char_ok  = (in_char_code >= FIRST_LETTER) && (char_off <= LAST_OFFSET) &&
                    (char_off < ALPHA_LIM);
  assign row_rd   = link_rdata;
  assign link_sel = row_rd[letter_r];
  assign new_node = nodes_used_r[NW-1:0];

  always_comb begin
    row_wr           = row_rd;
    row_wr[letter_r] = new_node;
  end

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    abort_nxt      = abort_r;
    nodes_used_nxt = nodes_used_r;
    op_nxt         = op_r;
    letter_nxt     = letter_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    link_we        = 1'b0;
    link_wdata     = '0;
    val_we         = 1'b0;
    val_waddr      = cursor_r;
    val_wdata      = '0;

    case (state_r)
      S_INIT: begin
        // cursor is the root here: clear its row and value entry
        link_we   = 1'b1;
        val_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (!in_end_of_key) begin
            if (abort_r == ST_OK) begin
              if (!char_ok) begin
                abort_nxt = ST_BAD_CHAR;
              end else begin
                op_nxt     = in_op;
                letter_nxt = char_off[LW-1:0];
                state_nxt  = S_LINK;
              end
            end
          end else begin
            cursor_nxt = '0;
            abort_nxt  = ST_OK;
            if (abort_r != ST_OK) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = abort_r;
              out_value_nxt  = '0;
            end else if (!in_op) begin
              val_we         = 1'b1;
              val_wdata      = {1'b1, in_entry_value[STORE_W-1:0]};
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_value_nxt  = '0;
            end else begin
              // value entry of the old cursor is read at this edge
              state_nxt = S_VAL;
            end
          end
        end
      end
      S_LINK: begin
        state_nxt = S_IDLE;
        if (link_sel != '0) begin
          cursor_nxt = link_sel;
        end else if (op_r) begin
          abort_nxt = ST_NOT_FOUND;
        end else if (nodes_used_r >= POOL_LIM) begin
          abort_nxt = ST_POOL_FULL;
        end else begin
          link_we        = 1'b1;
          link_wdata     = row_wr;
          val_we         = 1'b1;
          val_waddr      = new_node;
          cursor_nxt     = new_node;
          nodes_used_nxt = nodes_used_r + UW'(1);
          state_nxt      = S_ZERO;
        end
      end
      S_ZERO: begin
        // fresh node gets an empty child row before anything can read it
        link_we   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_VAL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (val_rdata[STORE_W]) begin
          out_status_nxt = ST_OK;
          out_value_nxt  = 32'(val_rdata[STORE_W-1:0]);
        end else begin
          out_status_nxt = ST_NOT_FOUND;
          out_value_nxt  = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cursor_r     <= '0;
      abort_r      <= ST_OK;
      nodes_used_r <= UW'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      abort_r      <= abort_nxt;
      nodes_used_r <= nodes_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    letter_r     <= letter_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  tkil_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (cursor_r),
    .wdata (link_wdata),
    .raddr (cursor_r),
    .rdata (link_rdata)
  );

  tkil_ram #(
    .WIDTH (STORE_W + 1),
    .DEPTH (NODE_COUNT)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (cursor_r),
    .rdata (val_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

  // a result comes only from an end item or a finished value read
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept && in_end_of_key) || $past(state_r == S_VAL)))
    else $error("result without an end item");

  // every result leaves the walk back at the root with no abort pending
  a_result_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cursor_r == '0) && (abort_r == ST_OK))
    else $error("walk not reset after result");

  // zeroing a row always follows exactly one allocation
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO) |-> ($past(state_r) == S_LINK) &&
      (nodes_used_r == $past(nodes_used_r) + UW'(1)) && (cursor_r == $past(new_node)))
    else $error("allocation bookkeeping broken");

  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_found_value == '0))
    else $error("failed result carries a value");

endmodule

`default_nettype wire
